// ===== design/taau_pkg.sv =====
// Shared types and constants for the table-driven two-argument arctangent unit.
// Used by taau_div and table_atan2_angle_unit; depends on nothing else.
package taau_pkg;

  localparam int RATIO_FRACTION_BITS_DEF = 10;
  localparam int MAG_W   = 32;
  localparam int INDEX_W = 11;
  localparam int ENTRY_W = 16;
  localparam int ANGLE_W = 17;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ANGLE = 1'b1;

  typedef struct packed {
    logic                      op;
    logic                      y_neg;
    logic                      x_neg;
    logic                      zero;
    logic                      swap;
    logic [INDEX_W-1:0]        idx;
    logic signed [ENTRY_W-1:0] val;
  } tag_t;

endpackage

// ===== design/taau_div.sv =====
// Pipelined restoring divider producing one quotient bit per stage.
// Depends on taau_pkg for the request tag that travels alongside.
module taau_div #(
  parameter int R = taau_pkg::RATIO_FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_in,
  input  taau_pkg::tag_t            tag_in,
  input  logic [taau_pkg::MAG_W-1:0] num_in,
  input  logic [taau_pkg::MAG_W-1:0] den_in,
  output logic                      vld_out,
  output taau_pkg::tag_t            tag_out,
  output logic [R:0]                q_out
);
  import taau_pkg::*;

  localparam int WW = MAG_W + R;

  logic             vld_r [0:R];
  tag_t             tag_r [0:R];
  logic [MAG_W-1:0] rem_r [0:R];
  logic [MAG_W-1:0] den_r [0:R];
  logic [R:0]       q_r   [0:R];

  for (genvar s = 0; s <= R; s++) begin : g_stage
    localparam int B = R - s;
    logic             vld_i;
    tag_t             tag_i;
    logic [MAG_W-1:0] rem_i;
    logic [MAG_W-1:0] den_i;
    logic [R:0]       q_i;
    logic [WW-1:0]    dsh;
    logic [WW-1:0]    diff;
    logic             take;

    if (s == 0) begin : g_first
      assign vld_i = vld_in;
      assign tag_i = tag_in;
      assign rem_i = num_in;
      assign den_i = den_in;
      assign q_i   = '0;
    end else begin : g_next
      assign vld_i = vld_r[s-1];
      assign tag_i = tag_r[s-1];
      assign rem_i = rem_r[s-1];
      assign den_i = den_r[s-1];
      assign q_i   = q_r[s-1];
    end

    assign dsh  = WW'(den_i) << B;
    assign take = WW'(rem_i) >= dsh;
    assign diff = WW'(rem_i) - dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
      tag_r[s] <= tag_i;
      den_r[s] <= den_i;
      rem_r[s] <= take ? diff[MAG_W-1:0] : rem_i;
      q_r[s]   <= take ? (q_i | ((R+1)'(1) << B)) : q_i;
    end
  end

  assign vld_out = vld_r[R];
  assign tag_out = tag_r[R];
  assign q_out   = q_r[R];

endmodule

// ===== design/table_atan2_angle_unit.sv =====
// Top level of the table-driven arctangent unit: magnitudes, divider, table, fixups.
// Depends on taau_pkg and taau_div.
// A compute request passes through the input register, the operand register, the divider
// stages, the table read register and the output register before its result strobe.
// Throughput: one request per cycle; busy stays low, as the receiver cannot stall.
// Reset clears the pipeline valid bits only; table contents stay undefined until written.
module table_atan2_angle_unit #(
  parameter int RATIO_FRACTION_BITS = taau_pkg::RATIO_FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic signed [taau_pkg::MAG_W-1:0]   in_y_value,
  input  logic signed [taau_pkg::MAG_W-1:0]   in_x_value,
  input  logic [taau_pkg::INDEX_W-1:0]        in_entry_index,
  input  logic signed [taau_pkg::ENTRY_W-1:0] in_entry_value,
  output logic                                out_valid,
  output logic signed [taau_pkg::ANGLE_W-1:0] out_angle
);
  import taau_pkg::*;

  localparam int R       = RATIO_FRACTION_BITS;
  localparam int TOP     = 1 << R;
  localparam int DEPTH   = TOP + 1;
  localparam logic [MAG_W-1:0] GUARD_MASK =
    32'h7FFF_FFFF & ~((32'd1 << (31 - R)) - 32'd1);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  logic             a_vld_r;
  tag_t             a_tag_r;
  logic [MAG_W-1:0] a_ay_r;
  logic [MAG_W-1:0] a_ax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
    a_tag_r.op    <= in_opcode;
    a_tag_r.y_neg <= in_y_value[MAG_W-1];
    a_tag_r.x_neg <= in_x_value[MAG_W-1];
    a_tag_r.zero  <= 1'b0;
    a_tag_r.swap  <= 1'b0;
    a_tag_r.idx   <= in_entry_index;
    a_tag_r.val   <= in_entry_value;
    a_ay_r <= in_y_value[MAG_W-1] ? (MAG_W'(0) - MAG_W'(in_y_value)) : MAG_W'(in_y_value);
    a_ax_r <= in_x_value[MAG_W-1] ? (MAG_W'(0) - MAG_W'(in_x_value)) : MAG_W'(in_x_value);
  end

  logic             b_swap;
  logic [MAG_W-1:0] b_n;
  logic [MAG_W-1:0] b_d;
  logic             b_guard;
  tag_t             b_tag;

  always_comb begin
    b_swap  = ~(a_ay_r < a_ax_r);
    b_n     = b_swap ? a_ax_r : a_ay_r;
    b_d     = b_swap ? a_ay_r : a_ax_r;
    b_guard = |(b_n & GUARD_MASK);
    b_tag       = a_tag_r;
    b_tag.swap  = b_swap;
    b_tag.zero  = (a_ay_r == '0) && (a_ax_r == '0);
  end

  logic             b_vld_r;
  tag_t             b_tag_r;
  logic [MAG_W-1:0] b_num_r;
  logic [MAG_W-1:0] b_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_tag_r <= b_tag;
    b_num_r <= b_guard ? b_n : (b_n << R);
    b_den_r <= b_guard ? (b_d >> R) : b_d;
  end

  logic       d_vld;
  tag_t       d_tag;
  logic [R:0] d_q;

  taau_div #(.R(R)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (b_vld_r),
    .tag_in  (b_tag_r),
    .num_in  (b_num_r),
    .den_in  (b_den_r),
    .vld_out (d_vld),
    .tag_out (d_tag),
    .q_out   (d_q)
  );

  logic signed [ENTRY_W-1:0] atan_mem [0:DEPTH-1];
  logic [R:0]                rd_addr;
  logic                      wr_en;
  logic signed [ENTRY_W-1:0] rd_data_r;
  logic                      c_vld_r;
  tag_t                      c_tag_r;

  assign rd_addr = (d_q > (R+1)'(TOP)) ? (R+1)'(TOP) : d_q;
  assign wr_en   = d_vld && (d_tag.op == OP_WRITE) &&
                   ((INDEX_W+R+1)'(d_tag.idx) <= (INDEX_W+R+1)'(TOP));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      atan_mem[(R+1)'(d_tag.idx)] <= d_tag.val;
    end
    rd_data_r <= atan_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= d_vld && (d_tag.op == OP_ANGLE);
    end
    c_tag_r <= d_tag;
  end

  logic signed [ANGLE_W:0]   v0;
  logic signed [ANGLE_W:0]   v1;
  logic signed [ANGLE_W:0]   v2;
  logic signed [ANGLE_W-1:0] angle_nxt;
  logic                      out_valid_r;
  logic signed [ANGLE_W-1:0] out_angle_r;

  always_comb begin
    v0 = c_tag_r.swap ? ((ANGLE_W+1)'(1024) - (ANGLE_W+1)'(rd_data_r))
                      : (ANGLE_W+1)'(rd_data_r);
    v1 = c_tag_r.x_neg ? ((ANGLE_W+1)'(2048) - v0) : v0;
    v2 = c_tag_r.y_neg ? -v1 : v1;
    angle_nxt = c_tag_r.zero ? '0 : v2[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_vld_r;
    end
    out_angle_r <= angle_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for table_atan2_angle_unit: loads the arctangent table,
// then drives directed and random angle requests, mixed with random table writes, against an in-bench predictor.
// Depends on taau_pkg and the design files only.
`timescale 1ns / 100ps

module tb_top;
  import taau_pkg::*;

  localparam int FRAC    = RATIO_FRACTION_BITS_DEF;
  localparam int TOP     = 1 << FRAC;
  localparam int LIMIT   = 400000;

  typedef struct {
    logic                      op;
    logic signed [MAG_W-1:0]   y;
    logic signed [MAG_W-1:0]   x;
    logic [INDEX_W-1:0]        idx;
    logic signed [ENTRY_W-1:0] val;
    bit                        hold;
    bit                        steady;
  } request_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_opcode = OP_WRITE;
  logic signed [MAG_W-1:0] in_y_value = '0;
  logic signed [MAG_W-1:0] in_x_value = '0;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic signed [ENTRY_W-1:0] in_entry_value = '0;
  logic out_valid;
  logic signed [ANGLE_W-1:0] out_angle;

  request_t pending_q[$];
  logic signed [ANGLE_W-1:0] angle_q[$];
  logic signed [ENTRY_W-1:0] atan_table[TOP+1];
  bit stimulus_done = 0;
  int mismatches = 0;
  int cycles = 0;

  table_atan2_angle_unit dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [MAG_W-1:0] magnitude(logic [MAG_W-1:0] v);
    return v[MAG_W-1] ? -v : v;
  endfunction

  function automatic int octant_index(logic [MAG_W-1:0] n, logic [MAG_W-1:0] d);
    logic [MAG_W-1:0] q;
    logic [MAG_W-1:0] dd;
    logic [MAG_W-1:0] nn;
    if (n[30:31-FRAC] != 0) begin
      dd = d >> FRAC;
      q = (dd != 0) ? n / dd : TOP;
    end else begin
      nn = n << FRAC;
      q = (d != 0) ? nn / d : TOP;
    end
    return (q > TOP) ? TOP : int'(q);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] angle_of(logic [MAG_W-1:0] y,
                                                         logic [MAG_W-1:0] x);
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] ax;
    int v;
    ay = magnitude(y);
    ax = magnitude(x);
    if (ay == 0 && ax == 0) return '0;
    if (ay < ax) v = atan_table[octant_index(ay, ax)];
    else v = 1024 - atan_table[octant_index(ax, ay)];
    if (x[MAG_W-1]) v = 2048 - v;
    if (y[MAG_W-1]) v = -v;
    return v[ANGLE_W-1:0];
  endfunction

  task automatic add_angle(logic [MAG_W-1:0] y, logic [MAG_W-1:0] x,
                           bit hold = 0, bit steady = 0);
    pending_q.push_back('{OP_ANGLE, y, x, '0, '0, hold, steady});
  endtask

  task automatic add_write(logic [INDEX_W-1:0] idx, logic [ENTRY_W-1:0] val);
    pending_q.push_back('{OP_WRITE, $urandom, $urandom, idx, val, 0, 0});
  endtask

  function automatic logic [MAG_W-1:0] rand_component();
    int w;
    w = $urandom_range(32, 1);
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h0;
      default: return $urandom >> (32 - w);
    endcase
  endfunction

  initial begin
    for (int i = 0; i <= TOP; i++) begin
      if (i == 0) add_write(INDEX_W'(i), 16'h8000);
      else if (i == TOP) add_write(INDEX_W'(i), 16'h7FFF);
      else add_write(INDEX_W'(i), ENTRY_W'((i * 512) / TOP + $urandom_range(3, 0)));
    end
    add_write(INDEX_W'(TOP + 1), 16'h1234);
    add_write(11'h7FF, 16'hFFFF);
    add_angle(32'h0, 32'h0);
    add_angle(32'h8000_0000, 32'h8000_0000);
    add_angle(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_angle(32'h8000_0000, 32'h0);
    add_angle(32'h0, 32'h8000_0000);
    add_angle(32'h7FFF_FFFF, 32'h8000_0000);
    add_angle(32'h1, 32'h7FFF_FFFF);
    add_angle(32'hFFFF_FFFF, 32'h0);
    add_angle(32'h0, 32'hFFFF_FFFF);
    add_angle(32'h4000_0000, 32'h7FFF_FFFF, 1);
    add_angle(32'h0020_0000, 32'hF000_0000);
    add_angle(32'h001F_FFFF, 32'h8000_0001);
    add_angle(32'h5555_5555, 32'hAAAA_AAAB);
    add_angle(32'h3, 32'h5);
    for (int i = 0; i < 210; i++) begin
      if ($urandom_range(99, 0) < 12) begin
        add_write($urandom_range(99, 0) < 10 ? INDEX_W'($urandom_range(2047, 0))
                                             : INDEX_W'($urandom_range(TOP, 0)),
                  ENTRY_W'($urandom));
      end else begin
        add_angle(rand_component(), rand_component(), i == 160,
                  i >= 40 && i < 130);
      end
    end
    stimulus_done = 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    request_t r;
    bit go;
    if (!rst_n) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        if (in_opcode == OP_WRITE) begin
          if (in_entry_index <= TOP) atan_table[in_entry_index] = in_entry_value;
        end else begin
          angle_q.push_back(angle_of(in_y_value, in_x_value));
        end
      end
      if (!(start && busy)) begin
        go = 0;
        if (pending_q.size() != 0) begin
          r = pending_q[0];
          go = (r.steady || $urandom_range(99, 0) >= 32) &&
               !(r.hold && angle_q.size() != 0);
        end
        if (go) begin
          void'(pending_q.pop_front());
          in_opcode <= r.op;
          in_y_value <= r.y;
          in_x_value <= r.x;
          in_entry_index <= r.idx;
          in_entry_value <= r.val;
          start <= 1;
        end else begin
          start <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic signed [ANGLE_W-1:0] want;
    if (rst_n && out_valid) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: angle %0d", out_angle);
      end else begin
        want = angle_q.pop_front();
        if (out_angle !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch: expected %0d, got %0d", want, out_angle);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    wait (stimulus_done && pending_q.size() == 0 && !start && angle_q.size() == 0);
    repeat (24) @(posedge clk);
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/taau_pkg.sv
design/taau_div.sv
design/table_atan2_angle_unit.sv
verif/tb_top.sv
